FILE: sv/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared payload structs, command and status codes, and the decoded work
// item that passes from the command front end to the execution back end.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Command codes on the input channel. Code 7 is unused and acts as a no-op.
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ_IDX   = 3'd4,
    CMD_WRITE_IDX  = 3'd5,
    CMD_REVERSE    = 3'd6
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Operation class produced by the front end.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH,
    OP_POP,
    OP_READ,
    OP_WRITE,
    OP_REV
  } op_t;

  // Input item.
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_in;
    logic [5:0] index;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_out;
    logic [6:0] count;
  } out_t;

  // Decoded work item held in the command queue.
  typedef struct packed {
    op_t        op;
    logic       at_front;
    logic [7:0] data;
    logic [5:0] index;
  } work_t;

  // Command queue between front and back end.
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

endpackage

FILE: sv/deq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue command front end
// Decodes each incoming command into an operation class and an end selector,
// and buffers the decoded work in a short queue for the back end.
// ----------------------------------------------------------------------------
module deq_front
  import deq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_data,
  output logic  wk_valid,
  input  logic  wk_ready,
  output work_t wk
);

  work_t            dec;
  work_t            q_r [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             push, pop;

  // Classify the command.
  always_comb begin
    dec.data     = in_data.data_in;
    dec.index    = in_data.index;
    dec.at_front = 1'b0;
    dec.op       = OP_NOP;
    case (in_data.cmd)
      CMD_PUSH_FRONT: begin
        dec.op       = OP_PUSH;
        dec.at_front = 1'b1;
      end
      CMD_PUSH_BACK: begin
        dec.op = OP_PUSH;
      end
      CMD_POP_FRONT: begin
        dec.op       = OP_POP;
        dec.at_front = 1'b1;
      end
      CMD_POP_BACK: begin
        dec.op = OP_POP;
      end
      CMD_READ_IDX: begin
        dec.op = OP_READ;
      end
      CMD_WRITE_IDX: begin
        dec.op = OP_WRITE;
      end
      CMD_REVERSE: begin
        dec.op = OP_REV;
      end
      default: begin
        dec.op = OP_NOP;
      end
    endcase
  end

  // Queue handshake.
  assign in_ready = (cnt_r != QCW'(QDEPTH));
  assign wk_valid = (cnt_r != '0);
  assign wk       = q_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = wk_valid && wk_ready;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue entries carry payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

FILE: sv/deq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue execution back end
// Owns the circular element store, the head pointer, the fill count and the
// orientation flag. Executes one decoded command per cycle while its result
// register is free or being taken, and holds each result there until taken.
// ----------------------------------------------------------------------------
module deq_back
  import deq_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 8
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wk_valid,
  output logic  wk_ready,
  input  work_t wk,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = (DATA_WIDTH < 8) ? DATA_WIDTH : 8;
  localparam int XW = (CW > 6) ? CW : 6;

  logic [SW-1:0] mem_r [DEPTH];
  logic [SW-1:0] rd_data_r;

  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          rev_r, rev_nxt;

  logic          res_vld_r;
  status_t       res_status_r, res_status_nxt;
  logic [CW-1:0] res_count_r;
  logic          res_rd_r, res_rd_nxt;

  logic          exec;
  logic          full, empty, in_range, low_end;
  logic [PW-1:0] addr;
  logic          mem_we, mem_re;
  logic [CW-1:0] fill_m1, rev_off;
  logic [PW-1:0] idx_off;

  // Add an offset below DEPTH to a slot, wrapping modulo DEPTH.
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
                                             input logic [PW-1:0] b);
    logic [PW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (PW+1)'(DEPTH)) begin
      sum = sum - (PW+1)'(DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  assign exec     = wk_valid && (!res_vld_r || out_ready);
  assign wk_ready = exec;

  assign full     = (fill_r == CW'(DEPTH));
  assign empty    = (fill_r == '0);
  assign in_range = (XW'(wk.index) < XW'(fill_r));
  assign low_end  = (wk.at_front != rev_r);
  assign fill_m1  = fill_r - 1'b1;
  assign rev_off  = fill_m1 - CW'(wk.index);
  assign idx_off  = rev_r ? PW'(rev_off) : PW'(wk.index);

  // Command execution: state update, store address and result status.
  always_comb begin
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    rev_nxt        = rev_r;
    addr           = wrap_add(head_r, idx_off);
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    res_status_nxt = ST_OK;
    res_rd_nxt     = 1'b0;
    case (wk.op)
      OP_PUSH: begin
        if (full) begin
          res_status_nxt = ST_FULL;
        end else begin
          if (low_end) begin
            head_nxt = (head_r == '0) ? PW'(DEPTH - 1) : head_r - 1'b1;
            addr     = head_nxt;
          end else begin
            addr = wrap_add(head_r, PW'(fill_r));
          end
          mem_we   = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end
      OP_POP: begin
        if (empty) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          if (low_end) begin
            addr     = head_r;
            head_nxt = wrap_add(head_r, PW'(1));
          end else begin
            addr = wrap_add(head_r, PW'(fill_m1));
          end
          mem_re     = 1'b1;
          res_rd_nxt = 1'b1;
          fill_nxt   = fill_m1;
        end
      end
      OP_READ: begin
        if (!in_range) begin
          res_status_nxt = ST_RANGE;
        end else begin
          mem_re     = 1'b1;
          res_rd_nxt = 1'b1;
        end
      end
      OP_WRITE: begin
        if (!in_range) begin
          res_status_nxt = ST_RANGE;
        end else begin
          mem_we = 1'b1;
        end
      end
      OP_REV: begin
        rev_nxt = !rev_r;
      end
      default: begin
        res_status_nxt = ST_OK;
      end
    endcase
  end

  // Control state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      fill_r    <= '0;
      rev_r     <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (exec) begin
        head_r <= head_nxt;
        fill_r <= fill_nxt;
        rev_r  <= rev_nxt;
      end
      if (exec) begin
        res_vld_r <= 1'b1;
      end else if (out_ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res_status_r <= res_status_nxt;
      res_count_r  <= fill_nxt;
      res_rd_r     <= res_rd_nxt;
    end
  end

  // Element store: at most one access per command, read data registered.
  always_ff @(posedge clk) begin
    if (exec && mem_we) begin
      mem_r[addr] <= SW'(wk.data);
    end
    if (exec && mem_re) begin
      rd_data_r <= mem_r[addr];
    end
  end

  // Result transfer.
  assign out_valid         = res_vld_r;
  assign out_data.status   = res_status_r;
  assign out_data.data_out = res_rd_r ? 8'(rd_data_r) : 8'd0;
  assign out_data.count    = 7'(res_count_r);

endmodule

FILE: sv/double_ended_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue top level
// Command front end with a two-entry command queue, feeding the execution
// back end that holds the circular element store.
// ----------------------------------------------------------------------------
// The block accepts one command per cycle and returns exactly one result per
// command, in order. A command waits in the command queue, then passes
// through the execution stage, whose single-port store read is registered
// alongside the result register, before the result can be taken. Sustained
// throughput is one command per cycle as long as results are taken; the
// command queue and the result register let either side stall on its own.
// Reverse only flips an orientation flag, so every command touches at most
// one store entry. Entries never written read back undefined, but only held
// entries are ever read.
module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic  wk_valid;
  logic  wk_ready;
  work_t wk;

  deq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .wk_valid (wk_valid),
    .wk_ready (wk_ready),
    .wk       (wk)
  );

  deq_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wk_valid  (wk_valid),
    .wk_ready  (wk_ready),
    .wk        (wk),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: sim/double_ended_queue_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives command streams through the valid/ready input channel with random
// gaps and result back-pressure. An in-bench deque predictor computes the
// status, data and count of every accepted command. The monitor then checks
// each result transfer against the oldest prediction, in order.
// ----------------------------------------------------------------------------
module double_ended_queue_top_test;
  import deq_pkg::*;

  localparam int          DEPTH      = 64;
  localparam logic [2:0]  CMD_UNUSED = 3'd7;  // spare code, behaves as a no-op
  localparam int          STALL_LIMIT = 2000;
  localparam int          TAIL_CYCLES = 20;
  localparam int          RANDOM_ITEMS = 1600;

  // Stimulus shaping for the random part.
  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mode_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  in_t  pending_cmds[$];
  out_t expected_results[$];
  int   error_count = 0;
  int   cycle_count = 0;
  int   stall_cycles = 0;
  logic calm;

  // Predictor state: circular store, head slot, fill level and orientation.
  logic [7:0] deq_mem[DEPTH];
  logic [5:0] deq_head = '0;
  logic [6:0] deq_fill = '0;
  logic       deq_rev  = 1'b0;

  // Generator's view of the fill level, used to aim indexes at held entries.
  int gen_fill = 0;

  double_ended_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock generation, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Physical slot of logical position pos, honoring the orientation flag.
  function automatic logic [5:0] slot_of(logic [5:0] pos);
    if (deq_rev) begin
      return deq_head + deq_fill[5:0] - 6'd1 - pos;
    end
    return deq_head + pos;
  endfunction

  // Apply one command to the predicted deque and return its expected result.
  function automatic out_t apply_command(in_t c);
    out_t       r;
    logic [5:0] slot;
    r = '0;
    case (c.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (deq_fill == 7'(DEPTH)) begin
          r.status = ST_FULL;
        end else begin
          // The logical front grows below head in normal order.
          if ((c.cmd == CMD_PUSH_FRONT) != deq_rev) begin
            deq_head = deq_head - 6'd1;
            slot = deq_head;
          end else begin
            slot = deq_head + deq_fill[5:0];
          end
          deq_mem[slot] = c.data_in;
          deq_fill = deq_fill + 7'd1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (deq_fill == '0) begin
          r.status = ST_EMPTY;
        end else begin
          if ((c.cmd == CMD_POP_FRONT) != deq_rev) begin
            r.data_out = deq_mem[deq_head];
            deq_head = deq_head + 6'd1;
          end else begin
            slot = deq_head + deq_fill[5:0] - 6'd1;
            r.data_out = deq_mem[slot];
          end
          deq_fill = deq_fill - 7'd1;
        end
      end
      CMD_READ_IDX: begin
        if ({1'b0, c.index} >= deq_fill) begin
          r.status = ST_RANGE;
        end else begin
          r.data_out = deq_mem[slot_of(c.index)];
        end
      end
      CMD_WRITE_IDX: begin
        if ({1'b0, c.index} >= deq_fill) begin
          r.status = ST_RANGE;
        end else begin
          deq_mem[slot_of(c.index)] = c.data_in;
        end
      end
      CMD_REVERSE: begin
        deq_rev = !deq_rev;
      end
      default: begin
      end
    endcase
    r.count = deq_fill;
    return r;
  endfunction

  function automatic in_t make_cmd(logic [2:0] cmd, logic [7:0] value, logic [5:0] pos);
    in_t c;
    c.cmd     = cmd;
    c.data_in = value;
    c.index   = pos;
    return c;
  endfunction

  // Queue one command and keep the generator's fill estimate in step.
  task automatic queue_cmd(in_t c);
    pending_cmds.push_back(c);
    if ((c.cmd == CMD_PUSH_FRONT || c.cmd == CMD_PUSH_BACK) && gen_fill < DEPTH) begin
      gen_fill++;
    end else if ((c.cmd == CMD_POP_FRONT || c.cmd == CMD_POP_BACK) && gen_fill > 0) begin
      gen_fill--;
    end
  endtask

  // Random command weighted by the current mode; indexes mostly hit held entries.
  function automatic in_t random_cmd(mode_t mode);
    int         roll;
    int         push_pct;
    int         pop_pct;
    logic [2:0] cmd;
    logic [5:0] pos;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  begin push_pct = 75; pop_pct = 10; end
      MODE_DRAIN: begin push_pct = 10; pop_pct = 75; end
      default:    begin push_pct = 30; pop_pct = 30; end
    endcase
    if (roll < push_pct) begin
      cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end else if (roll < push_pct + pop_pct) begin
      cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    end else if (roll < 94) begin
      cmd = $urandom_range(0, 1) ? CMD_WRITE_IDX : CMD_READ_IDX;
    end else if (roll < 98) begin
      cmd = CMD_REVERSE;
    end else begin
      cmd = CMD_UNUSED;
    end
    if (gen_fill > 0 && $urandom_range(0, 3) != 0) begin
      pos = 6'($urandom_range(0, gen_fill - 1));
    end else begin
      pos = 6'($urandom_range(0, 63));
    end
    return make_cmd(cmd, 8'($urandom_range(0, 255)), pos);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Idling and back-pressure are switched off for one stretch of each period of the cycle counter.
  assign calm = (cycle_count % 3000) < 600;

  // Input driver: a new transfer is offered only once the previous one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_cmds.size() > 0 && (calm || $urandom_range(0, 99) >= 37)) begin
        in_data  <= pending_cmds.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 37);
    end
  end

  // Monitor: predict on each command transfer, check each result transfer.
  always @(posedge clk) begin : monitor
    out_t want;
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_command(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending (count)", int'(out_data.count), -1);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            report_mismatch("status", int'(out_data.status), int'(want.status));
          end
          if (out_data.data_out !== want.data_out) begin
            report_mismatch("data_out", int'(out_data.data_out), int'(want.data_out));
          end
          if (out_data.count !== want.count) begin
            report_mismatch("count", int'(out_data.count), int'(want.count));
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t ns: watchdog expired, no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int    issued;
    int    seg_len;
    mode_t mode;

    // Directed part: empty-queue corners, field extremes, wrap and orientation.
    queue_cmd(make_cmd(CMD_REVERSE,    8'h00, 6'd0));
    queue_cmd(make_cmd(CMD_POP_FRONT,  8'hFF, 6'd63));
    queue_cmd(make_cmd(CMD_POP_BACK,   8'h00, 6'd0));
    queue_cmd(make_cmd(CMD_READ_IDX,   8'h00, 6'd0));
    queue_cmd(make_cmd(CMD_WRITE_IDX,  8'hFF, 6'd63));
    queue_cmd(make_cmd(CMD_UNUSED,     8'hFF, 6'd63));
    queue_cmd(make_cmd(CMD_REVERSE,    8'h00, 6'd0));
    queue_cmd(make_cmd(CMD_PUSH_FRONT, 8'h00, 6'd0));
    queue_cmd(make_cmd(CMD_PUSH_BACK,  8'hFF, 6'd63));
    queue_cmd(make_cmd(CMD_PUSH_FRONT, 8'hA5, 6'd0));
    queue_cmd(make_cmd(CMD_READ_IDX,   8'h00, 6'd0));
    queue_cmd(make_cmd(CMD_READ_IDX,   8'h00, 6'd2));
    queue_cmd(make_cmd(CMD_READ_IDX,   8'h00, 6'd3));
    queue_cmd(make_cmd(CMD_WRITE_IDX,  8'h5A, 6'd1));
    queue_cmd(make_cmd(CMD_WRITE_IDX,  8'h11, 6'd63));
    queue_cmd(make_cmd(CMD_REVERSE,    8'h00, 6'd0));
    queue_cmd(make_cmd(CMD_READ_IDX,   8'h00, 6'd0));
    queue_cmd(make_cmd(CMD_READ_IDX,   8'h00, 6'd1));
    queue_cmd(make_cmd(CMD_PUSH_BACK,  8'h3C, 6'd0));
    queue_cmd(make_cmd(CMD_POP_FRONT,  8'h00, 6'd0));
    queue_cmd(make_cmd(CMD_REVERSE,    8'h00, 6'd0));
    queue_cmd(make_cmd(CMD_POP_BACK,   8'h00, 6'd0));
    queue_cmd(make_cmd(CMD_POP_FRONT,  8'h00, 6'd0));
    queue_cmd(make_cmd(CMD_POP_BACK,   8'h00, 6'd0));
    queue_cmd(make_cmd(CMD_POP_FRONT,  8'h00, 6'd0));

    // Random part: segments weighted toward filling, toward draining, or mixed.
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      mode = mode_t'($urandom_range(0, 2));
      seg_len = $urandom_range(40, 140);
      repeat (seg_len) begin
        queue_cmd(random_cmd(mode));
        issued++;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_cmds.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/deq_pkg.sv
sv/deq_front.sv
sv/deq_back.sv
sv/double_ended_queue_top.sv
sim/double_ended_queue_top_test.sv
